>>> hdl/rsa_pkg.sv
// Shared types and constants of the video slice assembler.
// Used by rsa_front, rsa_back and the top level; depends on nothing.
package rsa_pkg;

  typedef enum logic [3:0] {
    PH_HDR, PH_SEQ, PH_LENA, PH_LENB, PH_LENC, PH_LEND, PH_POSA, PH_POSB,
    PH_POSC, PH_POSD, PH_PIC, PH_DATA, PH_PASS, PH_SKIP_BIG, PH_SKIP_SLICE
  } phase_t;

  typedef enum logic [1:0] {SRC_LIT, SRC_OFS, SRC_MEM} src_t;

  typedef enum logic [2:0] {
    ST_BUSY, ST_MORE, ST_DONE, ST_SLICE_OVF, ST_BUF_OVF, ST_TOO_LARGE, ST_EMPTY
  } status_t;

  // One classified input item.
  typedef struct packed {
    logic       drain;
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  // One result before its byte is resolved from the memories.
  typedef struct packed {
    src_t       src;
    logic [1:0] sel;
    logic [7:0] lit;
    logic       vld;
    logic       fend;
    status_t    status;
    logic       rdy;
    logic       last;
  } res_t;

  localparam logic [29:0] NUM_MAX     = 30'h3FFF_FFFF;
  localparam logic [5:0]  SLICE_MASK  = 6'h3F;
  localparam logic [6:0]  SEQ_MASK    = 7'h7F;
  localparam logic [1:0]  TYPE_SLICE  = 2'd0;
  localparam logic [1:0]  TYPE_WHOLE  = 2'd1;
  localparam logic [1:0]  TYPE_LAST   = 2'd2;
  localparam logic [1:0]  TYPE_PART   = 2'd3;
  localparam logic [3:0]  PREFIX_LAST = 4'd8;

  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    case (idx)
      4'd1, 4'd2, 4'd3, 4'd4: prefix_byte = 8'd1;
      default:                prefix_byte = 8'd0;
    endcase
  endfunction

endpackage

>>> hdl/rsa_front.sv
// Front end: accepts input items, classifies them and queues them.
// Two-entry queue decouples the stream input from the back end. Uses rsa_pkg.
module rsa_front
  import rsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  input  logic       in_tlast,
  output logic       head_valid,
  output item_t      head_item,
  input  logic       head_pop
);

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.drain = in_tuser[0];
    cls.data  = in_tdata;
    cls.first = in_tuser[1];
    cls.last  = in_tlast;
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (head_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, head_pop};
    end
  end

endmodule

>>> hdl/rsa_back.sv
// Back end: packet parser, frame memory, slice offset table and drain logic.
// Takes items from rsa_front, emits results through a read stage and an
// output register. Uses rsa_pkg.
module rsa_back
  import rsa_pkg::*;
#(
  parameter int FRAME_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  item_t       head_item,
  output logic        head_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int FSW = $clog2(FRAME_BYTES + 1);
  localparam int DPW = $clog2(FRAME_BYTES + 2048);
  localparam logic [31:0] FRAME_MAX = 32'(FRAME_BYTES);

  typedef struct packed {
    status_t        status;
    logic           ready;
    logic [FSW-1:0] wpos;
  } fin_t;

  function automatic fin_t finish(input logic [FSW-1:0] wpos,
                                  input logic [FSW-1:0] fsize,
                                  input logic [29:0] taken,
                                  input logic is_last_type);
    fin_t        f;
    logic [30:0] sum;
    sum      = 31'(wpos) + 31'(taken);
    f.wpos   = wpos;
    f.ready  = 1'b0;
    if (sum > 31'(fsize)) begin
      f.status = ST_BUF_OVF;
    end else begin
      f.wpos = sum[FSW-1:0];
      if (is_last_type || sum == 31'(fsize)) begin
        f.ready  = 1'b1;
        f.status = ST_DONE;
      end else begin
        f.status = ST_MORE;
      end
    end
    return f;
  endfunction

  // Parser and frame state.
  phase_t         phase_r, phase_nxt;
  logic [7:0]     hdr_r, hdr_nxt, seq_r, seq_nxt, pic_r, pic_nxt, curpic_r, curpic_nxt;
  logic [29:0]    acc_r, acc_nxt, len_r, len_nxt, pos_r, pos_nxt, taken_r, taken_nxt;
  logic [6:0]     total_r, total_nxt;
  logic [7:0]     count_r, count_nxt;
  logic [FSW-1:0] fsize_r, fsize_nxt, wpos_r, wpos_nxt;
  logic           ready_r, ready_nxt;
  logic [DPW-1:0] dpos_r, dpos_nxt;
  logic [3:0]     pfx_r, pfx_nxt;

  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [16:0] ofs_mem [128];
  logic [7:0]  fs_rd_r;
  logic [16:0] ofs_rd_r;

  logic           fs_we, ofs_we, is_pfx, fire, commit;
  logic [AW-1:0]  fs_wa, fs_ra;
  logic [6:0]     ofs_wa, ofs_ra;
  logic [16:0]    ofs_wd;
  res_t           res;

  res_t        s2_r;
  logic        s2_v_r, out_v_r, out_last_r;
  logic [13:0] out_data_r;
  logic [13:0] out_data_r_nxt;
  logic        out_free, s2_adv, s2_free;

  assign out_free = !out_v_r || out_tready;
  assign s2_adv   = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || s2_adv;
  assign fire     = head_valid && s2_free;
  assign commit   = fire && (!is_pfx || pfx_r == PREFIX_LAST);
  assign head_pop = commit;

  always_comb begin
    logic [1:0]     typ;
    logic [7:0]     b;
    phase_t         ph;
    logic [29:0]    v;
    logic [14:0]    v15;
    logic           newf, big;
    logic [7:0]     cnt1;
    logic [6:0]     tot1;
    logic [FSW-1:0] fsz1, wp1;
    logic [29:0]    tk1;
    logic [30:0]    addr;
    fin_t           f;
    logic [10:0]    sc8;
    logic [DPW-1:0] dm1, dk, dtot;
    typ = hdr_r[7:6];
    b   = head_item.data;
    ph  = head_item.first ? PH_HDR : phase_r;
    v = '0; v15 = '0; newf = 1'b0; big = 1'b0; cnt1 = count_r; tot1 = total_r;
    fsz1 = fsize_r; wp1 = wpos_r; tk1 = taken_r; addr = '0; f = '0;
    sc8 = {count_r[7:0], 3'b000};
    dm1 = dpos_r - DPW'(1);
    dk = dm1 - DPW'(sc8);
    dtot = DPW'(1) + DPW'(sc8) + DPW'(wpos_r);

    phase_nxt = phase_r; hdr_nxt = hdr_r; seq_nxt = seq_r; pic_nxt = pic_r;
    curpic_nxt = curpic_r; acc_nxt = acc_r; len_nxt = len_r; pos_nxt = pos_r;
    taken_nxt = taken_r; total_nxt = total_r; count_nxt = count_r;
    fsize_nxt = fsize_r; wpos_nxt = wpos_r; ready_nxt = ready_r; dpos_nxt = dpos_r;
    fs_we = 1'b0; fs_wa = '0; ofs_we = 1'b0; ofs_wa = '0; ofs_wd = '0;
    fs_ra = dk[AW-1:0]; ofs_ra = dm1[9:3];
    is_pfx = 1'b0;
    res = '{src: SRC_LIT, sel: 2'd0, lit: 8'd0, vld: 1'b0, fend: 1'b0,
            status: ST_BUSY, rdy: 1'b0, last: 1'b1};

    if (head_item.drain) begin
      if (!ready_r || count_r == 8'd0) begin
        res.status = ST_EMPTY;
      end else begin
        res.vld = 1'b1;
        if (dpos_r == '0) begin
          res.lit = count_r - 8'd1;
        end else if (dpos_r <= DPW'(sc8)) begin
          if (!dm1[2]) begin
            res.lit = (dm1[1:0] == 2'd0) ? 8'd1 : 8'd0;
          end else begin
            res.src = SRC_OFS;
            res.sel = dm1[1:0];
          end
        end else begin
          res.src = SRC_MEM;
        end
        if (dpos_r + DPW'(1) >= dtot) begin
          ready_nxt  = 1'b0;
          dpos_nxt   = '0;
          res.fend   = 1'b1;
          res.status = ST_DONE;
        end else begin
          dpos_nxt = dpos_r + DPW'(1);
        end
      end
    end else begin
      phase_nxt = ph;
      case (ph)
        PH_HDR: begin
          if (!head_item.first) begin
            res.status = ST_MORE;
          end else begin
            hdr_nxt   = b;
            phase_nxt = (b[7:6] == TYPE_PART) ? PH_LENA : PH_SEQ;
            res.status = head_item.last ? ST_MORE : ST_BUSY;
            if (head_item.last) phase_nxt = PH_HDR;
          end
        end
        PH_SEQ: begin
          seq_nxt = b;
          if (typ == TYPE_WHOLE) begin
            is_pfx = 1'b1;
            phase_nxt = head_item.last ? PH_HDR : PH_PASS;
            res.fend = head_item.last;
            res.status = head_item.last ? ST_DONE : ST_BUSY;
          end else begin
            phase_nxt = head_item.last ? PH_HDR : PH_LENA;
            res.status = head_item.last ? ST_MORE : ST_BUSY;
          end
        end
        PH_LENA, PH_POSA, PH_LENC, PH_POSC: begin
          acc_nxt = (ph == PH_LENA || ph == PH_POSA) ? {22'd0, b}
                                                      : {acc_r[21:0], b};
          case (ph)
            PH_LENA: phase_nxt = PH_LENB;
            PH_POSA: phase_nxt = PH_POSB;
            PH_LENC: phase_nxt = PH_LEND;
            default: phase_nxt = PH_POSD;
          endcase
          if (head_item.last) phase_nxt = PH_HDR;
          res.status = head_item.last ? ST_MORE : ST_BUSY;
        end
        PH_LENB, PH_POSB, PH_LEND, PH_POSD: begin
          v = {acc_r[21:0], b};
          if ((ph == PH_LENB || ph == PH_POSB) && !v[14]) begin
            acc_nxt   = {15'd0, v[14:0]};
            phase_nxt = (ph == PH_LENB) ? PH_LENC : PH_POSC;
          end else begin
            if (ph == PH_LENB || ph == PH_POSB) begin
              v15 = v[14:0];
              v = {16'd0, v15[13:0]};
            end
            if (ph == PH_POSB || ph == PH_POSD) begin
              pos_nxt   = v;
              phase_nxt = PH_PIC;
            end else begin
              len_nxt   = v;
              phase_nxt = PH_POSA;
            end
          end
          if (head_item.last) phase_nxt = PH_HDR;
          res.status = head_item.last ? ST_MORE : ST_BUSY;
        end
        PH_PIC: begin
          pic_nxt = b;
          if (typ == TYPE_PART) begin
            taken_nxt = '0;
            is_pfx = 1'b1;
            phase_nxt = head_item.last ? PH_HDR : PH_PASS;
            res.fend = head_item.last || len_r == '0;
            res.status = head_item.last ? ST_DONE : ST_BUSY;
          end else begin
            ready_nxt = 1'b0;
            dpos_nxt  = '0;
            newf = ((seq_r[6:0] & SEQ_MASK) == 7'd1) || (curpic_r != b) ||
                   (total_r == 7'd0);
            big  = newf && ({2'b00, len_r} > FRAME_MAX);
            if (big) begin
              total_nxt = '0; count_nxt = '0; fsize_nxt = '0; wpos_nxt = '0;
              phase_nxt = PH_SKIP_BIG;
            end else begin
              if (newf) begin
                tot1 = {hdr_r[5:0] & SLICE_MASK, 1'b1};
                fsz1 = len_r[FSW-1:0];
                wp1  = '0;
                cnt1 = '0;
                curpic_nxt = b;
              end
              if (cnt1 != 8'd255) cnt1 = cnt1 + 8'd1;
              total_nxt = tot1; fsize_nxt = fsz1; wpos_nxt = wp1; count_nxt = cnt1;
              if (cnt1 > {1'b0, tot1}) begin
                phase_nxt = PH_SKIP_SLICE;
              end else begin
                ofs_we = 1'b1;
                ofs_wa = cnt1[6:0] - 7'd1;
                ofs_wd = 17'(wp1);
                taken_nxt = '0;
                phase_nxt = PH_DATA;
              end
            end
            if (head_item.last) begin
              phase_nxt = PH_HDR;
              if (big) begin
                res.status = ST_TOO_LARGE;
              end else if (cnt1 > {1'b0, tot1}) begin
                res.status = ST_SLICE_OVF;
              end else begin
                f = finish(wp1, fsz1, 30'd0, typ == TYPE_LAST);
                res.status = f.status;
                wpos_nxt = f.wpos;
                if (f.ready) begin
                  ready_nxt = 1'b1;
                end
              end
            end
          end
        end
        PH_PASS: begin
          res.status = head_item.last ? ST_DONE : ST_BUSY;
          if (head_item.last) phase_nxt = PH_HDR;
          if (typ == TYPE_WHOLE) begin
            res.vld = 1'b1; res.lit = b; res.fend = head_item.last;
          end else if (taken_r < len_r) begin
            taken_nxt = taken_r + 30'd1;
            res.vld = 1'b1; res.lit = b;
            res.fend = head_item.last || (taken_nxt == len_r);
          end
        end
        PH_DATA: begin
          if (!(typ == TYPE_LAST && taken_r >= pos_r)) begin
            addr = 31'(wpos_r) + 31'(taken_r);
            if (addr < 31'(fsize_r) && addr < 31'(FRAME_MAX)) begin
              fs_we = 1'b1;
              fs_wa = addr[AW-1:0];
            end
            if (taken_r != NUM_MAX) tk1 = taken_r + 30'd1;
          end
          taken_nxt = tk1;
          if (head_item.last) begin
            phase_nxt = PH_HDR;
            f = finish(wpos_r, fsize_r, tk1, typ == TYPE_LAST);
            res.status = f.status;
            wpos_nxt = f.wpos;
            if (f.ready) begin
              ready_nxt = 1'b1;
              dpos_nxt  = '0;
            end
          end
        end
        PH_SKIP_BIG, PH_SKIP_SLICE: begin
          if (head_item.last) begin
            phase_nxt  = PH_HDR;
            res.status = (ph == PH_SKIP_BIG) ? ST_TOO_LARGE : ST_SLICE_OVF;
          end
        end
        default: begin
          phase_nxt  = PH_HDR;
          res.status = ST_MORE;
        end
      endcase
    end

    // The nine-byte prefix goes out byte by byte; state changes on the last.
    pfx_nxt = pfx_r;
    if (is_pfx) begin
      res.vld = 1'b1;
      res.src = SRC_LIT;
      res.lit = prefix_byte(pfx_r);
      if (pfx_r != PREFIX_LAST) begin
        res.fend   = 1'b0;
        res.status = ST_BUSY;
        res.last   = 1'b0;
        if (fire) pfx_nxt = pfx_r + 4'd1;
      end else if (fire) begin
        pfx_nxt = 4'd0;
      end
    end
    res.rdy = (is_pfx && pfx_r != PREFIX_LAST) ? ready_r : ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (commit && fs_we) frame_mem[fs_wa] <= head_item.data;
    if (fire) fs_rd_r <= frame_mem[fs_ra];
  end

  always_ff @(posedge clk) begin
    if (commit && ofs_we) ofs_mem[ofs_wa] <= ofs_wd;
    if (fire) ofs_rd_r <= ofs_mem[ofs_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR; hdr_r <= '0; seq_r <= '0; pic_r <= '0; curpic_r <= '0;
      acc_r <= '0; len_r <= '0; pos_r <= '0; taken_r <= '0; total_r <= '0;
      count_r <= '0; fsize_r <= '0; wpos_r <= '0; ready_r <= 1'b0;
      dpos_r <= '0; pfx_r <= '0;
    end else begin
      pfx_r <= pfx_nxt;
      if (commit) begin
        phase_r <= phase_nxt; hdr_r <= hdr_nxt; seq_r <= seq_nxt; pic_r <= pic_nxt;
        curpic_r <= curpic_nxt; acc_r <= acc_nxt; len_r <= len_nxt; pos_r <= pos_nxt;
        taken_r <= taken_nxt; total_r <= total_nxt; count_r <= count_nxt;
        fsize_r <= fsize_nxt; wpos_r <= wpos_nxt; ready_r <= ready_nxt;
        dpos_r <= dpos_nxt;
      end
    end
  end

  // Read stage: the memory data registered at fire lines up with s2_r.
  always_ff @(posedge clk) begin
    if (fire) s2_r <= res;
  end

  always_comb begin
    logic [7:0] byte_v;
    case (s2_r.src)
      SRC_OFS: begin
        case (s2_r.sel)
          2'd0:    byte_v = ofs_rd_r[7:0];
          2'd1:    byte_v = ofs_rd_r[15:8];
          2'd2:    byte_v = {7'd0, ofs_rd_r[16]};
          default: byte_v = 8'd0;
        endcase
      end
      SRC_MEM: byte_v = fs_rd_r;
      default: byte_v = s2_r.lit;
    endcase
    out_tdata = {2'b00, out_data_r};
    if (s2_adv) begin
      out_data_r_nxt = {s2_r.rdy, s2_r.status, s2_r.fend, s2_r.vld, byte_v};
    end else begin
      out_data_r_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_data_r <= out_data_r_nxt;
      out_last_r <= s2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_free) s2_v_r <= fire;
      if (out_free) out_v_r <= s2_v_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;

  a_pfx_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (pfx_r != 4'd0) |-> head_valid)
    else $error("prefix in progress without a queued item");
  a_ready_count: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (count_r != 8'd0 && count_r <= {1'b0, total_r}))
    else $error("ready frame with bad slice count");
  a_wpos_size: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= fsize_r)
    else $error("commit position beyond frame size");
  a_pfx_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (head_pop && is_pfx) |-> (pfx_r == PREFIX_LAST))
    else $error("prefix item popped early");

endmodule

>>> hdl/realvideo_slice_assembler_unit.sv
// Video slice assembler: one input item per cycle is taken while no prefix is being sent
// and the output does not stall, and each item gives one result, except the item that
// completes the header of a whole-frame packet (the sequence byte of a type 1 packet,
// the picture byte of a type 3 packet), which gives the nine prefix results and stays in
// the input queue until the last of them is issued. Results pass a read stage and an
// output register, and out_tvalid is driven from that output register.
// Frame store depth is FRAME_BYTES. Depends on rsa_pkg, rsa_front and rsa_back.
module realvideo_slice_assembler_unit
  import rsa_pkg::*;
#(
  parameter int FRAME_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // packet_byte
  input  logic [1:0]  in_tuser,   // command, first_of_packet
  input  logic        in_tlast,   // last_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte, out_valid, frame_end, status,
                                  // assembled_ready, zero fill
  output logic        out_tlast   // run_last
);

  logic  head_valid, head_pop;
  item_t head_item;

  rsa_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .head_valid, .head_item, .head_pop
  );

  rsa_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk, .rst_n, .head_valid, .head_item, .head_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

>>> test/tb_realvideo_slice_assembler_unit.sv
// Self-checking testbench for realvideo_slice_assembler_unit: packet and drain items go in,
// a built-in predictor of the slice reassembly works out every result byte and status.
// Depends on rsa_pkg and the assembler RTL.
`timescale 1ns / 1ps

module tb_realvideo_slice_assembler_unit;
  import rsa_pkg::*;

  localparam int FRAME_LIMIT = 65536;
  localparam int IDLE_LIMIT  = 5000;

  typedef struct {
    logic [7:0] data;
    bit         vld;
    bit         fend;
    status_t    status;
    bit         rdy;
    bit         last;
  } frame_res_t;

  class slice_scoreboard;
    phase_t      phase;
    bit [7:0]    hdr, seq_b, pic, cur_pic;
    bit [29:0]   acc, len2, pos, taken;
    int unsigned slices, count, fsize, wpos, dpos;
    bit          ready;
    bit [7:0]    store [FRAME_LIMIT];
    int unsigned ofs [128];
    frame_res_t  step_q[$];
    frame_res_t  pending_q[$];
    int          errors;

    function void put(bit [7:0] b, bit v, bit fe, status_t st);
      frame_res_t r;
      r.data = v ? b : 8'd0;
      r.vld = v;
      r.fend = fe;
      r.status = st;
      step_q.push_back(r);
    endfunction

    function void put_prefix(bit fe, status_t st);
      for (int i = 0; i < 8; i++) put((i >= 1 && i <= 4) ? 8'd1 : 8'd0, 1, 0, ST_BUSY);
      put(8'd0, 1, fe, st);
    endfunction

    function status_t finish_slice();
      if (longint'(wpos) + taken > fsize) return ST_BUF_OVF;
      wpos += taken;
      if (hdr[7:6] == TYPE_LAST || wpos == fsize) begin
        ready = 1;
        dpos = 0;
        return ST_DONE;
      end
      return ST_MORE;
    endfunction

    function phase_t start_slice();
      ready = 0;
      dpos = 0;
      if (seq_b[6:0] == 7'd1 || cur_pic != pic || slices == 0) begin
        if (len2 > FRAME_LIMIT) begin
          slices = 0;
          count = 0;
          fsize = 0;
          wpos = 0;
          return PH_SKIP_BIG;
        end
        slices = 2 * hdr[5:0] + 1;
        fsize = len2;
        wpos = 0;
        count = 0;
        cur_pic = pic;
      end
      if (count < 255) count++;
      if (count > slices) return PH_SKIP_SLICE;
      ofs[(count - 1) % 128] = wpos;
      taken = 0;
      return PH_DATA;
    endfunction

    function int unsigned drain_len();
      return 1 + 8 * count + wpos;
    endfunction

    function void drain();
      int unsigned d, k, b;
      bit [7:0] val;
      if (!ready || count == 0) begin
        put(8'd0, 0, 0, ST_EMPTY);
        return;
      end
      d = dpos;
      if (d == 0) val = count - 1;
      else if (d <= 8 * count) begin
        k = ((d - 1) / 8) % 128;
        b = (d - 1) % 8;
        if (b < 4) val = (b == 0);
        else val = ofs[k] >> (8 * (b - 4));
      end else begin
        k = d - 1 - 8 * count;
        val = (k < FRAME_LIMIT) ? store[k] : 8'd0;
      end
      if (d + 1 >= drain_len()) begin
        ready = 0;
        dpos = 0;
        put(val, 1, 1, ST_DONE);
      end else begin
        dpos = d + 1;
        put(val, 1, 0, ST_BUSY);
      end
    endfunction

    function void packet(bit [7:0] b, bit first, bit last);
      bit [1:0] kind;
      bit [29:0] v;
      status_t st;
      int unsigned addr;
      if (first) phase = PH_HDR;
      kind = hdr[7:6];
      case (phase)
        PH_HDR: begin
          if (!first) begin
            put(0, 0, 0, ST_MORE);
            return;
          end
          hdr = b;
          phase = (b[7:6] == TYPE_PART) ? PH_LENA : PH_SEQ;
        end
        PH_SEQ: begin
          seq_b = b;
          if (kind == TYPE_WHOLE) begin
            put_prefix(last, last ? ST_DONE : ST_BUSY);
            phase = last ? PH_HDR : PH_PASS;
            return;
          end
          phase = PH_LENA;
        end
        PH_LENA, PH_POSA, PH_LENC, PH_POSC: begin
          acc = (phase == PH_LENA || phase == PH_POSA) ? 30'(b) : ((acc << 8) | b);
          phase = phase_t'(phase + 1);
        end
        PH_LENB, PH_POSB, PH_LEND, PH_POSD: begin
          v = (acc << 8) | b;
          if (phase == PH_LENB || phase == PH_POSB) begin
            v = v & 30'h7FFF;
            if (v < 30'h4000) begin
              acc = v;
              phase = phase_t'(phase + 1);
              if (last) begin
                phase = PH_HDR;
                put(0, 0, 0, ST_MORE);
              end else put(0, 0, 0, ST_BUSY);
              return;
            end
            v -= 30'h4000;
          end
          if (phase >= PH_POSA) begin
            pos = v;
            phase = PH_PIC;
          end else begin
            len2 = v;
            phase = PH_POSA;
          end
        end
        PH_PIC: begin
          pic = b;
          if (kind == TYPE_PART) begin
            taken = 0;
            put_prefix(last || len2 == 0, last ? ST_DONE : ST_BUSY);
            phase = last ? PH_HDR : PH_PASS;
            return;
          end
          phase = start_slice();
          if (!last) begin
            put(0, 0, 0, ST_BUSY);
            return;
          end
          st = (phase == PH_DATA) ? finish_slice() :
               (phase == PH_SKIP_BIG) ? ST_TOO_LARGE : ST_SLICE_OVF;
          phase = PH_HDR;
          put(0, 0, 0, st);
          return;
        end
        PH_PASS: begin
          st = last ? ST_DONE : ST_BUSY;
          if (last) phase = PH_HDR;
          if (kind == TYPE_WHOLE) put(b, 1, last, st);
          else if (taken < len2) begin
            taken++;
            put(b, 1, last || taken == len2, st);
          end else put(0, 0, 0, st);
          return;
        end
        PH_DATA: begin
          if (!(kind == TYPE_LAST && taken >= pos)) begin
            addr = wpos + taken;
            if (addr < fsize && addr < FRAME_LIMIT) store[addr] = b;
            if (taken < NUM_MAX) taken++;
          end
          if (!last) begin
            put(0, 0, 0, ST_BUSY);
            return;
          end
          phase = PH_HDR;
          put(0, 0, 0, finish_slice());
          return;
        end
        PH_SKIP_BIG, PH_SKIP_SLICE: begin
          st = !last ? ST_BUSY : (phase == PH_SKIP_BIG) ? ST_TOO_LARGE : ST_SLICE_OVF;
          if (last) phase = PH_HDR;
          put(0, 0, 0, st);
          return;
        end
        default: begin
          phase = PH_HDR;
          put(0, 0, 0, ST_MORE);
          return;
        end
      endcase
      if (last) begin
        phase = PH_HDR;
        put(0, 0, 0, ST_MORE);
      end else put(0, 0, 0, ST_BUSY);
    endfunction

    // Called once per accepted input item.
    function void note_item(bit cmd, bit [7:0] b, bit first, bit last);
      frame_res_t r;
      step_q.delete();
      if (cmd) drain();
      else packet(b, first, last);
      foreach (step_q[i]) begin
        r = step_q[i];
        r.rdy = ready;
        r.last = (i == step_q.size() - 1);
        pending_q.push_back(r);
      end
    endfunction

    function void check_result(logic [15:0] d, logic l);
      frame_res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result tdata=%h tlast=%b", d, l);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[7:0] !== e.data) begin
        $error("out_byte expected %h actual %h", e.data, d[7:0]); errors++;
      end
      if (d[8] !== e.vld) begin
        $error("out_valid expected %b actual %b", e.vld, d[8]); errors++;
      end
      if (d[9] !== e.fend) begin
        $error("frame_end expected %b actual %b", e.fend, d[9]); errors++;
      end
      if (d[12:10] !== e.status) begin
        $error("status expected %0d actual %0d", e.status, d[12:10]); errors++;
      end
      if (d[13] !== e.rdy) begin
        $error("assembled_ready expected %b actual %b", e.rdy, d[13]); errors++;
      end
      if (l !== e.last) begin
        $error("run_last expected %b actual %b", e.last, l); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready, out_tlast;
  logic [15:0] out_tdata;

  slice_scoreboard sb;
  bit          calm;
  int          idle_cycles;
  int          items_sent;
  bit [7:0]    pkt_q[$];

  realvideo_slice_assembler_unit dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic send_item(bit cmd, bit [7:0] b, bit first, bit last);
    while (!calm && $urandom_range(99) < 35) @(negedge clk);
    in_tvalid = 1;
    in_tuser = {first, cmd};
    in_tdata = b;
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, b, first, last);
    items_sent++;
    @(negedge clk);
    in_tvalid = 0;
  endtask

  function automatic void push_num(bit [29:0] v, bit long_form);
    bit [15:0] w;
    if (!long_form && v < 30'h4000) begin
      w = 16'(v) + 16'h4000;
      w[15] = $urandom_range(1);
      pkt_q.push_back(w[15:8]);
      pkt_q.push_back(w[7:0]);
    end else begin
      w = {$urandom_range(1) ? 1'b1 : 1'b0, 1'b0, v[29:16]};
      pkt_q.push_back(w[15:8]);
      pkt_q.push_back(w[7:0]);
      pkt_q.push_back(v[15:8]);
      pkt_q.push_back(v[7:0]);
    end
  endfunction

  // Builds a packet of the given kind with n_pay random payload bytes.
  function automatic void build(bit [1:0] kind, bit [5:0] hlow, bit [7:0] seqv,
                                bit [29:0] l2, bit [29:0] p, bit [7:0] picv, int n_pay);
    pkt_q.delete();
    pkt_q.push_back({kind, hlow});
    if (kind != TYPE_PART) pkt_q.push_back(seqv);
    if (kind != TYPE_WHOLE) begin
      push_num(l2, $urandom_range(3) == 0);
      push_num(p, $urandom_range(3) == 0);
      pkt_q.push_back(picv);
    end
    repeat (n_pay) pkt_q.push_back($urandom);
  endfunction

  // A packet may be cut short to n_bytes; its last flag is sent only when mark_last is set.
  task automatic ship(int n_bytes, bit mark_last);
    for (int i = 0; i < n_bytes; i++)
      send_item(0, pkt_q[i], i == 0, mark_last && i == n_bytes - 1);
  endtask

  task automatic drain_frame(int extra);
    int n;
    n = sb.ready ? sb.drain_len() : 0;
    repeat (n + extra) send_item(1, $urandom, $urandom_range(1), $urandom_range(1));
  endtask

  // One picture split into slices, sometimes with too many slices or too much data.
  task automatic slice_frame();
    int total_len, n_sl, left, sz, i;
    bit [5:0] hlow;
    bit [7:0] picv;
    total_len = $urandom_range(1, 20);
    n_sl = $urandom_range(1, 3);
    hlow = $urandom_range(7) == 0 ? 6'($urandom) : 6'($urandom_range(1));
    picv = $urandom;
    left = total_len;
    for (i = 0; i < n_sl; i++) begin
      sz = (i == n_sl - 1) ? left : $urandom_range(0, left);
      left -= sz;
      if ($urandom_range(9) == 0) sz++;
      if (i == n_sl - 1 && $urandom_range(1)) begin
        build(TYPE_LAST, hlow, (i == 0) ? 8'h01 : 8'($urandom), total_len,
              $urandom_range(0, sz + 2), picv, sz);
      end else begin
        build(TYPE_SLICE, hlow, (i == 0 && $urandom_range(1)) ? 8'h81 : 8'($urandom),
              total_len, $urandom, picv, sz);
      end
      ship(pkt_q.size(), 1);
    end
    drain_frame($urandom_range(3) == 0);
  endtask

  task automatic random_case();
    int sel, n;
    sel = $urandom_range(99);
    if (sel < 55) slice_frame();
    else if (sel < 67) begin
      build(TYPE_WHOLE, $urandom, $urandom, 0, 0, 0, $urandom_range(0, 6));
      ship(pkt_q.size(), 1);
    end else if (sel < 79) begin
      n = $urandom_range(0, 6);
      build(TYPE_PART, $urandom, 0, $urandom_range(0, 6), $urandom, $urandom, n);
      ship(pkt_q.size(), 1);
    end else if (sel < 86) begin
      build(2'($urandom), $urandom, $urandom, $urandom_range(0, 8), $urandom,
            $urandom, 3);
      ship($urandom_range(1, pkt_q.size()), $urandom_range(1));
    end else if (sel < 93) begin
      send_item(0, $urandom, 0, $urandom_range(1));
    end else begin
      send_item(1, $urandom, $urandom_range(1), $urandom_range(1));
    end
  endtask

  initial begin
    sb = new();
    sb.phase = PH_HDR;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    in_tlast = 0;
    out_tready = 0;
    calm = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;

    // Directed part: empty drain, stray byte, pass-through kinds, an oversized slice, a cut packet, a drained frame.
    send_item(1, 8'hFF, 1, 1);
    send_item(0, 8'hFF, 0, 0);
    build(TYPE_WHOLE, 6'h3F, 8'hFF, 0, 0, 0, 2);
    ship(pkt_q.size(), 1);
    build(TYPE_WHOLE, 6'h00, 8'h00, 0, 0, 0, 0);
    ship(pkt_q.size(), 1);
    build(TYPE_PART, 6'h00, 0, 2, 30'h3FFF_FFFF, 8'hFF, 4);
    ship(pkt_q.size(), 1);
    build(TYPE_PART, 6'h00, 0, 0, 0, 8'h00, 1);
    ship(pkt_q.size(), 1);
    build(TYPE_SLICE, 6'h00, 8'h01, 70000, 0, 8'h11, 2);
    ship(pkt_q.size(), 1);
    build(TYPE_SLICE, 6'h3F, 8'h01, 3, 0, 8'h22, 2);
    ship(4, 1);
    build(TYPE_SLICE, 6'h00, 8'h01, 2, 0, 8'h33, 2);
    ship(pkt_q.size(), 1);
    drain_frame(1);

    for (int k = 0; items_sent < 340; k++) begin
      calm = (k >= 20 && k < 35);
      random_case();
    end
    calm = 0;

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready = calm || $urandom_range(99) >= 35;
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

>>> sim.f
hdl/rsa_pkg.sv
hdl/rsa_front.sv
hdl/rsa_back.sv
hdl/realvideo_slice_assembler_unit.sv
test/tb_realvideo_slice_assembler_unit.sv
